>>> rtl/bpc_pkg.sv
// Package for the BPE pre-token chunk splitter: chunk modes, word types,
// byte class helpers and the per-byte chunk decision function.
// No dependencies.
package bpc_pkg;

  typedef enum logic [3:0] {
    MODE_NONE       = 4'd0,
    MODE_LETTER     = 4'd1,
    MODE_DIGIT      = 4'd2,
    MODE_SPACE      = 4'd3,
    MODE_OTHER      = 4'd4,
    MODE_APOS_R     = 4'd5,
    MODE_APOS_V     = 4'd6,
    MODE_APOS_L     = 4'd7,
    MODE_CONTR_LAST = 4'd8
  } chunk_mode_t;

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  // One output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       begins_chunk;
    logic       text_end;
  } out_word_t;

  // Pushes into the output queue for one accepted input word.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

  // Chunk tracking state and the begin flag from one decision.
  typedef struct packed {
    logic        begins;
    chunk_mode_t mode;
    logic [1:0]  run_len;
  } decision_t;

  function automatic logic byte_is_alpha(input logic [7:0] c);
    byte_is_alpha = (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)
                 || (c >= CH_HIGH);
  endfunction

  function automatic logic byte_is_num(input logic [7:0] c);
    byte_is_num = (c >= CH_0 && c <= CH_9);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Open a new chunk at byte h with optional lookahead nx.
  function automatic decision_t open_chunk(input logic [7:0] h, input logic has_nx,
                                           input logic [7:0] nx);
    decision_t d;
    d.begins  = 1'b1;
    d.run_len = 2'd0;
    if (h == CH_APOS && has_nx) begin
      if (nx == CH_S || nx == CH_T || nx == CH_M || nx == CH_D) begin
        d.mode = MODE_CONTR_LAST;
      end else if (nx == CH_R) begin
        d.mode = MODE_APOS_R;
      end else if (nx == CH_V) begin
        d.mode = MODE_APOS_V;
      end else if (nx == CH_L) begin
        d.mode = MODE_APOS_L;
      end else begin
        d.mode = MODE_OTHER;
      end
    end else if (h == CH_SPACE && has_nx && byte_is_alpha(nx)) begin
      d.mode = MODE_LETTER;
    end else if (h == CH_SPACE && has_nx && byte_is_num(nx)) begin
      d.mode = MODE_DIGIT;
    end else if (byte_is_alpha(h)) begin
      d.mode = MODE_LETTER;
    end else if (byte_is_num(h)) begin
      d.mode    = MODE_DIGIT;
      d.run_len = 2'd1;
    end else if (is_ws(h)) begin
      d.mode = MODE_SPACE;
    end else begin
      d.mode = MODE_OTHER;
    end
    return d;
  endfunction

  // Decide whether h starts a chunk, given the open chunk state.
  function automatic decision_t decide(input chunk_mode_t mode, input logic [1:0] run_len,
                                       input logic [1:0] max_run, input logic [7:0] h,
                                       input logic has_nx, input logic [7:0] nx);
    decision_t d;
    logic      stay;
    d.begins  = 1'b0;
    d.mode    = mode;
    d.run_len = run_len;
    stay      = 1'b0;
    case (mode)
      MODE_LETTER: stay = byte_is_alpha(h);
      MODE_DIGIT: begin
        if (byte_is_num(h) && run_len < max_run) begin
          stay      = 1'b1;
          d.run_len = run_len + 2'd1;
        end
      end
      MODE_SPACE: stay = is_ws(h);
      MODE_OTHER: stay = !byte_is_alpha(h) && !byte_is_num(h) && !is_ws(h);
      MODE_CONTR_LAST: begin
        stay   = 1'b1;
        d.mode = MODE_NONE;
      end
      MODE_APOS_R, MODE_APOS_V: begin
        if (has_nx && nx == CH_E) begin
          stay   = 1'b1;
          d.mode = MODE_CONTR_LAST;
        end
      end
      MODE_APOS_L: begin
        if (has_nx && nx == CH_L) begin
          stay   = 1'b1;
          d.mode = MODE_CONTR_LAST;
        end
      end
      default: stay = 1'b0;
    endcase
    if (!stay) begin
      d = open_chunk(h, has_nx, nx);
    end
    return d;
  endfunction

endpackage

>>> rtl/bpc_if.sv
// Handshake channel interfaces for the BPE pre-token chunk splitter:
// the text byte input channel and the chunk-marked output channel.
// No dependencies.
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       begins_chunk;
  logic       text_end;

  modport source (output valid, output out_byte, output begins_chunk, output text_end,
                  input ready);
  modport sink (input valid, input out_byte, input begins_chunk, input text_end,
                output ready);
endinterface

>>> rtl/bpc_out_queue.sv
// Three-word output queue of the chunk splitter; takes zero, one or two
// words per cycle and hands out one. Depends on bpc_pkg.
module bpc_out_queue
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      pop,
  input  logic      one_word_max,
  output logic      has_room,
  output logic      head_valid,
  output out_word_t head
);

  localparam int Depth = 3;

  out_word_t  slots      [Depth];
  out_word_t  slots_next [Depth];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] base;
  logic [1:0] base_up;

  assign head_valid = (count != 2'd0);
  assign head       = slots[0];
  // Room for two words keeps a final byte with a held byte from overflowing;
  // with one free slot, take a word that can push at most one.
  assign has_room   = (count <= 2'd1) || (count == 2'd2 && one_word_max);

  always_comb begin
    base       = count - {1'b0, pop};
    base_up    = base + 2'd1;
    count_next = base + push.count;
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        slots_next[i] = slots[i + 1];
      end else begin
        slots_next[i] = slots[i];
      end
    end
    if (push.count != 2'd0 && base < 2'(Depth)) begin
      slots_next[base] = push.first;
    end
    if (push.count == 2'd2 && base_up < 2'(Depth)) begin
      slots_next[base_up] = push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < Depth; i++) begin
      slots[i] <= slots_next[i];
    end
  end

endmodule

>>> rtl/bpe_pretoken_chunk_splitter.sv
// Pre-token chunk splitter for byte-level BPE: holds one byte of lookahead,
// marks each chunk start and queues the marked bytes for the output channel.
// Depends on bpc_pkg, bpc_if and bpc_out_queue.
//
// Order: a byte is held until the next byte is accepted and then goes into
//   the output queue; a final byte goes into the queue when it is accepted,
//   behind the held byte when there is one.
// Throughput: one byte per cycle with no gap, also across text boundaries,
//   while the queue has room; the three-word queue absorbs the extra word of
//   a final byte, and input stalls only once the output has been held off.
// Reset: synchronous, clears the held byte, the chunk state and the queue.
module bpe_pretoken_chunk_splitter
  import bpc_pkg::*;
#(
  parameter int MAX_DIGIT_RUN = 3
) (
  input logic       clk,
  input logic       rst,
  bpc_in_if.sink    text_in,
  bpc_out_if.source chunk_out
);

  localparam logic [1:0] MaxRun = 2'(MAX_DIGIT_RUN);

  // Lookahead and chunk tracking state.
  logic        [7:0] held_byte;
  logic              held_valid;
  chunk_mode_t       chunk_mode;
  logic        [1:0] digit_run_length;

  logic              accept;
  logic              has_room;
  decision_t         held_dec;     // decision on the held byte, new byte as lookahead
  decision_t         mid_state;    // chunk state after the held byte
  decision_t         final_dec;    // decision on a final byte, no lookahead
  push_t             push;
  out_word_t         head;
  logic              head_valid;

  assign text_in.ready = has_room;
  assign accept        = text_in.valid && has_room;

  always_comb begin
    held_dec = decide(chunk_mode, digit_run_length, MaxRun, held_byte, 1'b1,
                      text_in.in_byte);
    // Advance the state past the held byte only when one is held.
    if (held_valid) begin
      mid_state = held_dec;
    end else begin
      mid_state.begins  = 1'b0;
      mid_state.mode    = chunk_mode;
      mid_state.run_len = digit_run_length;
    end
    final_dec = decide(mid_state.mode, mid_state.run_len, MaxRun, text_in.in_byte,
                       1'b0, 8'h00);
  end

  // Build up to two output words for this input word.
  always_comb begin
    out_word_t held_word;
    out_word_t fin_word;
    held_word.out_byte     = held_byte;
    held_word.begins_chunk = held_dec.begins;
    held_word.text_end     = 1'b0;
    fin_word.out_byte      = text_in.in_byte;
    fin_word.begins_chunk  = final_dec.begins;
    fin_word.text_end      = 1'b1;
    push.count  = 2'd0;
    push.first  = held_word;
    push.second = fin_word;
    if (accept) begin
      push.count = {1'b0, held_valid} + {1'b0, text_in.is_final};
      if (!held_valid) begin
        push.first = fin_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte        <= 8'h00;
      held_valid       <= 1'b0;
      chunk_mode       <= MODE_NONE;
      digit_run_length <= 2'd0;
    end else if (accept) begin
      if (text_in.is_final) begin
        // Flush: the next word begins a new text.
        held_byte        <= 8'h00;
        held_valid       <= 1'b0;
        chunk_mode       <= MODE_NONE;
        digit_run_length <= 2'd0;
      end else begin
        held_byte        <= text_in.in_byte;
        held_valid       <= 1'b1;
        chunk_mode       <= mid_state.mode;
        digit_run_length <= mid_state.run_len;
      end
    end
  end

  // With nothing held, the next input word pushes at most one word.
  bpc_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop          (chunk_out.valid && chunk_out.ready),
    .one_word_max (!held_valid),
    .has_room     (has_room),
    .head_valid   (head_valid),
    .head         (head)
  );

  assign chunk_out.valid        = head_valid;
  assign chunk_out.out_byte     = head.out_byte;
  assign chunk_out.begins_chunk = head.begins_chunk;
  assign chunk_out.text_end     = head.text_end;

endmodule

>>> tb/sv/testbench.sv
// Testbench for bpe_pretoken_chunk_splitter: directed and random text byte
// streams, checked word by word against an in-bench chunk-boundary predictor.
// Depends on bpc_pkg, bpc_if and the splitter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int MAX_DIGITS       = 3;
  localparam int DIRECTED_ROWS    = 25;
  localparam int RANDOM_ITEMS     = 1400;
  localparam int QUIET_ITEMS      = 200;   // tail of the run with no idling
  localparam int LONG_HOLD_AT     = DIRECTED_ROWS + 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PAUSE_AT         = DIRECTED_ROWS + 700;
  localparam int DRAIN_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int NO_FLAG          = -1;    // begin flag left to the predictor

  // One input word of the stimulus; known_begin holds a typed begin flag.
  typedef struct {
    logic [7:0] data;
    logic       is_last;
    int         known_begin;
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpc_in_if  text_ch ();
  bpc_out_if chunk_ch ();

  bpe_pretoken_chunk_splitter #(
    .MAX_DIGIT_RUN(MAX_DIGITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_ch),
    .chunk_out(chunk_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed text. The first byte of each text always opens a chunk, so only
  // those flags are typed in; the rest go through the predictor.
  text_item_t directed_rows [DIRECTED_ROWS] = '{
    '{8'hFF,    1'b1, 1},        // one-byte text, nothing held
    '{CH_APOS,  1'b0, 1},        // 're contraction
    '{CH_R,     1'b0, NO_FLAG},
    '{CH_E,     1'b0, NO_FLAG},
    '{CH_SPACE, 1'b0, NO_FLAG},  // space joins the digit run
    '{CH_0,     1'b0, NO_FLAG},
    '{CH_9,     1'b0, NO_FLAG},
    '{CH_0,     1'b0, NO_FLAG},
    '{CH_9,     1'b0, NO_FLAG},  // fourth digit splits the run
    '{CH_APOS,  1'b0, NO_FLAG},  // 'l without the second l
    '{CH_L,     1'b0, NO_FLAG},
    '{CH_LC_Z,  1'b0, NO_FLAG},
    '{CH_TAB,   1'b0, NO_FLAG},  // whitespace run swallows the space
    '{CH_SPACE, 1'b0, NO_FLAG},
    '{CH_LC_A,  1'b0, NO_FLAG},
    '{8'h00,    1'b0, NO_FLAG},
    '{CH_HIGH,  1'b0, NO_FLAG},  // high byte counts as a letter
    '{CH_APOS,  1'b1, NO_FLAG},  // apostrophe as the last byte
    '{CH_APOS,  1'b0, 1},        // 'd contraction
    '{CH_D,     1'b0, NO_FLAG},
    '{CH_SPACE, 1'b1, NO_FLAG},  // space as the last byte
    '{CH_CR,    1'b0, 1},
    '{CH_APOS,  1'b0, NO_FLAG},  // 'v without the e
    '{CH_V,     1'b0, NO_FLAG},
    '{CH_UC_Z,  1'b1, NO_FLAG}
  };

  text_item_t  text_items[$];
  logic [7:0]  text_buf[$];

  // Predictor state: one byte of lookahead plus the open chunk.
  chunk_mode_t cur_mode    = MODE_NONE;
  logic [1:0]  run_digits  = 2'd0;
  logic [7:0]  look_byte   = 8'd0;
  logic        look_valid  = 1'b0;
  int          look_known  = NO_FLAG;
  out_word_t   pending_words[$];

  int   n_taken        = 0;
  int   n_words        = 0;
  int   n_errors       = 0;
  int   stuck_cycles   = 0;
  bit   quiet          = 1'b0;
  bit   long_hold_done = 1'b0;

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z) || c >= CH_HIGH;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic space_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Append one byte to the text being built.
  function automatic void add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  // Return 1 when byte h opens a chunk; advance the chunk state either way.
  // nx is the byte after h, valid only when has_nx is set.
  function automatic logic chunk_starts(input logic [7:0] h, input logic has_nx,
                                        input logic [7:0] nx);
    logic stay;
    stay = 1'b0;
    case (cur_mode)
      MODE_LETTER: stay = letter_byte(h);
      MODE_DIGIT: begin
        if (digit_byte(h) && run_digits < MAX_DIGITS) begin
          stay       = 1'b1;
          run_digits = run_digits + 2'd1;
        end
      end
      MODE_SPACE: stay = space_byte(h);
      MODE_OTHER: stay = !letter_byte(h) && !digit_byte(h) && !space_byte(h);
      MODE_CONTR_LAST: begin
        // last byte of a contraction: close it, the next byte opens anew
        stay     = 1'b1;
        cur_mode = MODE_NONE;
      end
      MODE_APOS_R, MODE_APOS_V: begin
        if (has_nx && nx == CH_E) begin
          stay     = 1'b1;
          cur_mode = MODE_CONTR_LAST;
        end
      end
      MODE_APOS_L: begin
        if (has_nx && nx == CH_L) begin
          stay     = 1'b1;
          cur_mode = MODE_CONTR_LAST;
        end
      end
      default: stay = 1'b0;
    endcase
    if (stay) begin
      return 1'b0;
    end
    run_digits = 2'd0;
    if (h == CH_APOS && has_nx) begin
      case (nx)
        CH_S, CH_T, CH_M, CH_D: cur_mode = MODE_CONTR_LAST;
        CH_R:    cur_mode = MODE_APOS_R;
        CH_V:    cur_mode = MODE_APOS_V;
        CH_L:    cur_mode = MODE_APOS_L;
        default: cur_mode = MODE_OTHER;
      endcase
    end else if (h == CH_SPACE && has_nx && letter_byte(nx)) begin
      cur_mode = MODE_LETTER;
    end else if (h == CH_SPACE && has_nx && digit_byte(nx)) begin
      cur_mode = MODE_DIGIT;   // joining space does not count as a digit
    end else if (letter_byte(h)) begin
      cur_mode = MODE_LETTER;
    end else if (digit_byte(h)) begin
      cur_mode   = MODE_DIGIT;
      run_digits = 2'd1;
    end else if (space_byte(h)) begin
      cur_mode = MODE_SPACE;
    end else begin
      cur_mode = MODE_OTHER;
    end
    return 1'b1;
  endfunction

  // Queue the words that one accepted input byte releases: the held byte
  // first, then the new byte itself when it ends the text.
  function automatic void take_byte(input logic [7:0] b, input logic fin, input int known);
    out_word_t w;
    if (look_valid) begin
      w.out_byte     = look_byte;
      w.begins_chunk = chunk_starts(look_byte, 1'b1, b);
      w.text_end     = 1'b0;
      if (look_known != NO_FLAG) begin
        w.begins_chunk = look_known[0];
      end
      pending_words.insert(pending_words.size(), w);
    end
    if (fin) begin
      w.out_byte     = b;
      w.begins_chunk = chunk_starts(b, 1'b0, 8'd0);
      w.text_end     = 1'b1;
      if (known != NO_FLAG) begin
        w.begins_chunk = known[0];
      end
      pending_words.insert(pending_words.size(), w);
      // end of text: back to the reset state
      cur_mode   = MODE_NONE;
      run_digits = 2'd0;
      look_byte  = 8'd0;
      look_valid = 1'b0;
      look_known = NO_FLAG;
    end else begin
      look_byte  = b;
      look_valid = 1'b1;
      look_known = known;
    end
  endfunction

  function automatic logic [7:0] word_letter();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) begin
      return 8'($urandom_range(CH_UC_A, CH_UC_Z));
    end else if (pick < 18) begin
      return 8'($urandom_range(CH_LC_A, CH_LC_Z));
    end
    return 8'($urandom_range(CH_HIGH, 8'hFF));
  endfunction

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 127));
    end while (letter_byte(b) || digit_byte(b) || space_byte(b));
    return b;
  endfunction

  // Append one token of plausible text to text_buf.
  task automatic append_token();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 10))
      0, 1: begin
        // contraction, sometimes cut short or broken
        add_byte(CH_APOS);
        case ($urandom_range(0, 10))
          0: add_byte(CH_S);
          1: add_byte(CH_T);
          2: begin add_byte(CH_R); add_byte(CH_E); end
          3: begin add_byte(CH_V); add_byte(CH_E); end
          4: add_byte(CH_M);
          5: begin add_byte(CH_L); add_byte(CH_L); end
          6: add_byte(CH_D);
          7: begin
            case ($urandom_range(0, 2))
              0: add_byte(CH_R);
              1: add_byte(CH_V);
              default: add_byte(CH_L);
            endcase
          end
          8: add_byte(8'($urandom));
          default: ;
        endcase
      end
      2, 3: repeat (n) add_byte(word_letter());
      4: begin
        add_byte(CH_SPACE);
        repeat (n) add_byte(word_letter());
      end
      5: repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(CH_0, CH_9)));
      6: begin
        add_byte(CH_SPACE);
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(CH_0, CH_9)));
      end
      7: begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 1) begin
            add_byte(CH_SPACE);
          end else begin
            add_byte(8'($urandom_range(CH_TAB, CH_CR)));
          end
        end
      end
      8: repeat (n) add_byte(other_byte());
      9: repeat (n) add_byte(8'($urandom));
      default: add_byte(CH_SPACE);
    endcase
  endtask

  // Append one whole text, mostly short; a tenth of them are pure noise.
  task automatic append_text();
    int target;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat (target) add_byte(8'($urandom));
    end else begin
      while (text_buf.size() < target) append_token();
    end
    foreach (text_buf[k]) begin
      text_items.insert(text_items.size(),
                        '{text_buf[k], k == text_buf.size() - 1, NO_FLAG});
    end
  endtask

  // Predict on every accepted input word, then check every accepted output
  // word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      take_byte(text_ch.in_byte, text_ch.is_final,
                (n_taken < text_items.size()) ? text_items[n_taken].known_begin : NO_FLAG);
      n_taken++;
    end
    if (!rst && chunk_ch.valid && chunk_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("word %0d: byte %h arrived with no word expected", n_words, chunk_ch.out_byte);
        n_errors++;
      end else begin
        want = pending_words.pop_front();
        if (chunk_ch.out_byte !== want.out_byte) begin
          $error("word %0d out_byte: expected %h, got %h", n_words, want.out_byte,
                 chunk_ch.out_byte);
          n_errors++;
        end
        if (chunk_ch.begins_chunk !== want.begins_chunk) begin
          $error("word %0d begins_chunk: expected %0d, got %0d", n_words,
                 want.begins_chunk, chunk_ch.begins_chunk);
          n_errors++;
        end
        if (chunk_ch.text_end !== want.text_end) begin
          $error("word %0d text_end: expected %0d, got %0d", n_words, want.text_end,
                 chunk_ch.text_end);
          n_errors++;
        end
      end
      n_words++;
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (chunk_ch.valid && chunk_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles, %0d words still expected", stuck_cycles,
             pending_words.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: ready in random bursts, one long hold-off so the block fills
  // up and stalls its input, and no stalls during the quiet tail.
  initial begin
    chunk_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && n_taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        chunk_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        chunk_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      chunk_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sender: build the stimulus, reset, then walk the directed table and
  // the random texts; finally drain and report.
  initial begin
    text_ch.valid    <= 1'b0;
    text_ch.in_byte  <= 8'd0;
    text_ch.is_final <= 1'b0;
    rst              <= 1'b1;

    foreach (directed_rows[r]) text_items.insert(text_items.size(), directed_rows[r]);
    while (text_items.size() < DIRECTED_ROWS + RANDOM_ITEMS) append_text();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < text_items.size(); i++) begin
      quiet = (i >= text_items.size() - QUIET_ITEMS);
      if (i == PAUSE_AT) begin
        // hold input until every expected word is out
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        text_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      // offer the next word and hold it until accepted
      text_ch.valid    <= 1'b1;
      text_ch.in_byte  <= text_items[i].data;
      text_ch.is_final <= text_items[i].is_last;
      do @(posedge clk); while (!text_ch.ready);
    end
    text_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_out_queue.sv
rtl/bpe_pretoken_chunk_splitter.sv
tb/sv/testbench.sv
